/* src/bbi_pkg.sv */
package bbi_pkg;

  localparam int CW = 24;
  localparam int FW = 16;
  localparam int PW = CW + FW + 1;
  localparam int AW = 4;
  localparam int DW = 32;
  localparam int IN_DW = 5 * CW + FW;
  localparam int OUT_DW = 4 * CW;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [FW-1:0] frac_t;
  typedef logic signed [PW-1:0] prod_t;

  typedef enum logic [1:0] {
    REG_GRAVITY     = 2'd0,
    REG_MIN_BOUNCE  = 2'd1,
    REG_RESTITUTION = 2'd2,
    REG_FRICTION    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    coord_t          gravity;
    logic [CW-2:0]   min_bounce;
    frac_t           restitution;
    frac_t           friction;
  } cfg_t;

  typedef struct packed {
    logic   valid;
    logic   rest;
    coord_t px;
    coord_t py;
    coord_t vx;
    coord_t vy;
    coord_t vx_fric;
    coord_t ground;
    frac_t  dt;
  } mid_t;

  function automatic prod_t mul_frac(input coord_t a, input frac_t f);
    prod_t ae;
    prod_t fe;
    ae = prod_t'(a);
    fe = prod_t'($signed({1'b0, f}));
    return ae * fe;
  endfunction

  function automatic coord_t frac_floor(input prod_t p);
    prod_t q;
    q = p >>> FW;
    return q[CW-1:0];
  endfunction

  function automatic coord_t sat_add(input coord_t a, input prod_t p);
    prod_t q;
    logic signed [CW+1:0] s;
    q = p >>> FW;
    s = $signed({{2{a[CW-1]}}, a}) + q[CW+1:0];
    if (s[CW+1:CW-1] == 3'b000 || s[CW+1:CW-1] == 3'b111) begin
      return s[CW-1:0];
    end else if (s[CW+1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

endpackage

/* src/bbi_regs.sv */
module bbi_regs
  import bbi_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [DW-1:0] pwdata,
  output logic [DW-1:0] prdata,
  output logic          pready,
  output cfg_t          cfg
);

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[AW-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        REG_GRAVITY:     cfg.gravity     <= pwdata[CW-1:0];
        REG_MIN_BOUNCE:  cfg.min_bounce  <= pwdata[CW-2:0];
        REG_RESTITUTION: cfg.restitution <= pwdata[FW-1:0];
        REG_FRICTION:    cfg.friction    <= pwdata[FW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GRAVITY:     prdata = DW'(unsigned'(cfg.gravity));
      REG_MIN_BOUNCE:  prdata = DW'(cfg.min_bounce);
      REG_RESTITUTION: prdata = DW'(cfg.restitution);
      REG_FRICTION:    prdata = DW'(cfg.friction);
      default:         prdata = '0;
    endcase
  end

endmodule

/* src/bbi_motion.sv */
module bbi_motion
  import bbi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  cfg_t             cfg,
  input  logic             in_valid,
  input  logic [IN_DW-1:0] in_data,
  input  logic             in_rest,
  output mid_t             mid
);

  logic   v1;
  logic   rest1;
  coord_t px1, py1, vx1, vy1, ground1;
  frac_t  dt1;

  logic   v2;
  logic   rest2;
  coord_t px2, py2, vx2, vy2, ground2;
  frac_t  dt2;
  prod_t  grav_p, pos_x_p, fric_p;

  coord_t vy_new;
  coord_t px_new;

  // stage 1: capture transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1     <= in_data[CW-1:0];
      py1     <= in_data[2*CW-1:CW];
      vx1     <= in_data[3*CW-1:2*CW];
      vy1     <= in_data[4*CW-1:3*CW];
      ground1 <= in_data[5*CW-1:4*CW];
      dt1     <= in_data[IN_DW-1:5*CW];
      rest1   <= in_rest;
    end
  end

  // stage 2: products that need only the input and the configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grav_p  <= mul_frac(cfg.gravity, dt1);
      pos_x_p <= mul_frac(vx1, dt1);
      fric_p  <= mul_frac(vx1, cfg.friction);
      px2     <= px1;
      py2     <= py1;
      vx2     <= vx1;
      vy2     <= vy1;
      ground2 <= ground1;
      dt2     <= dt1;
      rest2   <= rest1;
    end
  end

  // stage 3: apply gravity, move x; resting objects keep their inputs
  assign vy_new = rest2 ? vy2 : sat_add(vy2, grav_p);
  assign px_new = rest2 ? px2 : sat_add(px2, pos_x_p);

  always_ff @(posedge clk) begin
    if (rst) begin
      mid.valid <= 1'b0;
    end else if (en) begin
      mid.valid <= v2;
    end
    if (en) begin
      mid.rest    <= rest2;
      mid.px      <= px_new;
      mid.py      <= py2;
      mid.vx      <= vx2;
      mid.vy      <= vy_new;
      mid.vx_fric <= frac_floor(fric_p);
      mid.ground  <= ground2;
      mid.dt      <= dt2;
    end
  end

endmodule

/* src/bbi_contact.sv */
module bbi_contact
  import bbi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  cfg_t              cfg,
  input  mid_t              mid,
  output logic              out_valid,
  output logic [OUT_DW-1:0] out_data,
  output logic [1:0]        out_flags
);

  mid_t   s4;
  prod_t  pos_y_p;
  prod_t  rebound_p;

  coord_t py_new;
  logic   contact;
  logic   bounce;
  coord_t px_o, py_o, vx_o, vy_o;
  logic   resting_o, settled_o;

  // stage 4: products on the new vertical velocity
  always_ff @(posedge clk) begin
    if (rst) begin
      s4.valid <= 1'b0;
    end else if (en) begin
      s4.valid <= mid.valid;
    end
    if (en) begin
      s4.rest    <= mid.rest;
      s4.px      <= mid.px;
      s4.py      <= mid.py;
      s4.vx      <= mid.vx;
      s4.vy      <= mid.vy;
      s4.vx_fric <= mid.vx_fric;
      s4.ground  <= mid.ground;
      s4.dt      <= mid.dt;
      pos_y_p    <= mul_frac(mid.vy, mid.dt);
      rebound_p  <= mul_frac(mid.vy, cfg.restitution);
    end
  end

  // move y, test ground, pick bounce or settle
  assign py_new  = sat_add(s4.py, pos_y_p);
  assign contact = !s4.rest && !s4.vy[CW-1] && (py_new >= s4.ground);
  assign bounce  = s4.vy > $signed({1'b0, cfg.min_bounce});

  always_comb begin
    px_o      = s4.px;
    py_o      = s4.rest ? s4.py : py_new;
    vx_o      = s4.vx;
    vy_o      = s4.vy;
    resting_o = s4.rest;
    settled_o = 1'b0;
    if (contact) begin
      py_o = s4.ground;
      if (bounce) begin
        vx_o = s4.vx_fric;
        vy_o = -frac_floor(rebound_p);
      end else begin
        vx_o      = '0;
        vy_o      = '0;
        resting_o = 1'b1;
        settled_o = 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s4.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data  <= {vy_o, vx_o, py_o, px_o};
      out_flags <= {settled_o, resting_o};
    end
  end

  a_settled_rests: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_flags[1] |-> out_flags[0])
    else $error("settled result not marked resting");

  a_settled_still: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_flags[1] |-> out_data[OUT_DW-1:2*CW] == '0)
    else $error("settled result has nonzero velocity");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    en && s4.valid |=> out_valid)
    else $error("transaction lost between last stage and output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(s4) && $stable(out_data))
    else $error("stage changed while stalled");

endmodule

/* src/ballistic_bounce_integrator_top.sv */
// Ballistic bounce integrator: advances one object by one time step.
// Input stream (s_*): one transaction per object; s_tdata carries position,
// velocity, ground line and time step, s_tuser the resting flag.
// Output stream (m_*): one transaction per input transaction, in order, with
// the new position and velocity in m_tdata and the resting and settled flags
// in m_tuser.
// APB port: gravity, min bounce speed, restitution and friction at byte
// addresses 0, 4, 8 and 12; pready is always high. Write only while idle.
// Pipeline: four stages plus the output register.
// Throughput: one transaction per cycle while the output is not stalled; the
// multiplies sit in stages 2 and 4, the saturating adds in stage 3 and ahead
// of the output register.
// Reset: clears all stage valid bits and the configuration registers to zero.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.
module ballistic_bounce_integrator_top
  import bbi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AW-1:0]     paddr,
  input  logic [DW-1:0]     pwdata,
  output logic [DW-1:0]     prdata,
  output logic              pready,
  input  logic              s_tvalid,
  output logic              s_tready,
  // pos_x, pos_y, vel_x, vel_y, ground_line, time_step
  input  logic [IN_DW-1:0]  s_tdata,
  // resting
  input  logic              s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // new_pos_x, new_pos_y, new_vel_x, new_vel_y
  output logic [OUT_DW-1:0] m_tdata,
  // now_resting, just_settled
  output logic [1:0]        m_tuser
);

  cfg_t cfg;
  mid_t mid;
  logic en;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  bbi_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bbi_motion u_motion (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_data  (s_tdata),
    .in_rest  (s_tuser),
    .mid      (mid)
  );

  bbi_contact u_contact (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .mid       (mid),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .out_flags (m_tuser)
  );

endmodule
